/* rtl/tbc_pkg.sv */
// Shared types, constants and codes of the triangle box clipper.
`default_nettype none
package tbc_pkg;
   localparam int COORD_W    = 32;
   localparam int NUM_AXES   = 3;
   localparam int NUM_VERTS  = 3;
   localparam int REQ_W      = NUM_VERTS * NUM_AXES * COORD_W;
   localparam int RSP_W      = 2 * NUM_AXES * COORD_W;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam int PASS_W     = 3;
   localparam logic [PASS_W-1:0] NUM_PASSES = 3'd6;

   typedef logic [1:0] axis_type;
   localparam axis_type AXIS_NONE = 2'd3;
   localparam axis_type OTHER_AXES [NUM_AXES][2] =
      '{'{2'd1, 2'd2}, '{2'd0, 2'd2}, '{2'd0, 2'd1}};

   typedef logic [NUM_AXES-1:0][COORD_W-1:0] vert_type;

   typedef enum logic [2:0] {
      CSR_BOX_MIN_X,
      CSR_BOX_MIN_Y,
      CSR_BOX_MIN_Z,
      CSR_BOX_MAX_X,
      CSR_BOX_MAX_Y,
      CSR_BOX_MAX_Z,
      CSR_OUTPUT_MODE
   } csr_idx_type;

   typedef enum logic [1:0] {
      OUT_VERT,
      OUT_BOX,
      OUT_MISS
   } out_kind_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_SETUP,
      S_ORDER,
      S_PASS,
      S_EDGE,
      S_DIV,
      S_MUL,
      S_CROSS,
      S_NEXT,
      S_FINISH,
      S_BBOX,
      S_PREP,
      S_MISS,
      S_EMIT
   } state_type;

   typedef struct packed {
      logic         load;
      logic         setup;
      logic         order;
      logic         load_first;
      logic         use_first;
      logic         div_start;
      logic         mul;
      logic         write_cross;
      logic         write_next;
      logic         advance;
      logic         bbox_init;
      logic         bbox_acc;
      logic         load_out;
      out_kind_type out_kind;
      logic         out_last;
   } cmd_type;

   typedef struct packed {
      logic reject;
      logic skip_pass;
      logic emit_cross;
      logic emit_next;
      logic div_done;
      logic mode;
      logic out_last;
   } status_type;
endpackage
`default_nettype wire

/* rtl/tbc_div.sv */
// Bit-serial divider for the crossing parameter of a clipped edge.
`default_nettype none
module tbc_div
   import tbc_pkg::*;
#(
   parameter int FRAC_BITS = 16
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   input  wire logic [COORD_W:0]   num,
   input  wire logic [COORD_W:0]   den,
   output logic      [FRAC_BITS:0] quot,
   output logic                    done
);
   localparam int REM_W  = COORD_W + 2;
   localparam int STEP_W = $clog2(FRAC_BITS + 2);
   localparam logic [STEP_W-1:0] STEPS = STEP_W'(FRAC_BITS + 1);

   logic [REM_W-1:0]   rem_ff, rem_in, trial;
   logic [COORD_W:0]   den_ff, den_in;
   logic [FRAC_BITS:0] quot_ff, quot_in;
   logic [STEP_W-1:0]  step_ff, step_in;
   logic               first_ff, first_in, done_ff, done_in, bit_set;

   always_comb begin
      trial    = first_ff ? rem_ff : {rem_ff[REM_W-2:0], 1'b0};
      bit_set  = trial >= {1'b0, den_ff};
      rem_in   = rem_ff;
      den_in   = den_ff;
      quot_in  = quot_ff;
      step_in  = step_ff;
      first_in = first_ff;
      done_in  = 1'b0;
      if (start) begin
         rem_in   = {1'b0, num};
         den_in   = den;
         quot_in  = '0;
         step_in  = STEPS;
         first_in = 1'b1;
      end else if (step_ff != '0) begin
         rem_in   = bit_set ? trial - {1'b0, den_ff} : trial;
         quot_in  = {quot_ff[FRAC_BITS-1:0], bit_set};
         step_in  = step_ff - 1'b1;
         first_in = 1'b0;
         done_in  = step_ff == STEP_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= '0;
         done_ff <= 1'b0;
      end else begin
         step_ff <= step_in;
         done_ff <= done_in;
      end
      rem_ff   <= rem_in;
      den_ff   <= den_in;
      quot_ff  <= quot_in;
      first_ff <= first_in;
   end

   assign quot = quot_ff;
   assign done = done_ff;
endmodule
`default_nettype wire

/* rtl/tbc_datapath.sv */
// Datapath: registers, polygon buffers, plane tests, crossing arithmetic, output register.
`default_nettype none
module tbc_datapath
   import tbc_pkg::*;
#(
   parameter int MAX_VERTS = 9,
   parameter int FRAC_BITS = 16
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         csr_we,
   input  wire logic [CSR_ADDR_W-1:0]        csr_addr,
   input  wire logic [CSR_DATA_W-1:0]        csr_wdata,
   input  wire logic [REQ_W-1:0]             req_tdata,
   input  wire cmd_type                      cmd,
   input  wire logic [PASS_W-1:0]            pass_idx,
   input  wire logic                         src,
   input  wire logic [$clog2(MAX_VERTS)-1:0] rd_idx,
   input  wire logic [$clog2(MAX_VERTS)-1:0] wr_idx,
   output status_type                        status,
   output logic [RSP_W-1:0]                  rsp_tdata,
   output logic                              rsp_tuser,
   output logic                              rsp_tlast
);
   localparam int PW = FRAC_BITS + 2 + COORD_W + 1;
   localparam logic [PW-1:0] TRUNC_BIAS = {{(PW-FRAC_BITS){1'b0}}, {FRAC_BITS{1'b1}}};

   vert_type              poly_ff [2][MAX_VERTS];
   vert_type              bmin_ff, bmax_ff, c_ff, first_ff, lo_ff, hi_ff, out_lo_ff, out_hi_ff;
   logic                  mode_ff, out_user_ff, out_last_ff;
   axis_type              bflat_ff, tflat_ff, bflat, tflat, axis, a0, a1, tmp;
   axis_type              order_ff [NUM_AXES];
   axis_type              order_in [NUM_AXES];
   logic [COORD_W-1:0]    ext_ff [NUM_AXES];
   logic [COORD_W-1:0]    ext_in [NUM_AXES];
   vert_type              tri_in [NUM_VERTS];
   vert_type              rd_v, nxt_v, cross_v, box_lo, box_hi;
   logic [COORD_W-1:0]    plane, cv, nv, lo_c, hi_c;
   logic                  side, cin, nin;
   logic signed [COORD_W:0] num_s, den_s, diff0, diff1, span;
   logic [COORD_W:0]      num_mag, den_mag;
   logic [FRAC_BITS:0]    quot;
   logic                  div_done;
   logic signed [PW-1:0]  prod_ff [2];
   logic signed [PW-1:0]  biased0, biased1, sh0, sh1;

   always_comb begin
      for (int v = 0; v < NUM_VERTS; v++)
         for (int a = 0; a < NUM_AXES; a++)
            tri_in[v][a] = req_tdata[(v*NUM_AXES + a)*COORD_W +: COORD_W];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bmin_ff <= '0;
         bmax_ff <= '0;
         mode_ff <= 1'b0;
      end else if (csr_we) begin
         unique case (csr_idx_type'(csr_addr))
            CSR_BOX_MIN_X:   bmin_ff[0] <= csr_wdata;
            CSR_BOX_MIN_Y:   bmin_ff[1] <= csr_wdata;
            CSR_BOX_MIN_Z:   bmin_ff[2] <= csr_wdata;
            CSR_BOX_MAX_X:   bmax_ff[0] <= csr_wdata;
            CSR_BOX_MAX_Y:   bmax_ff[1] <= csr_wdata;
            CSR_BOX_MAX_Z:   bmax_ff[2] <= csr_wdata;
            CSR_OUTPUT_MODE: mode_ff    <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // flat axes and extents
   always_comb begin
      bflat = AXIS_NONE;
      tflat = AXIS_NONE;
      for (int a = 0; a < NUM_AXES; a++) begin
         lo_c = poly_ff[0][0][a];
         hi_c = poly_ff[0][0][a];
         for (int v = 1; v < NUM_VERTS; v++) begin
            if ($signed(poly_ff[0][v][a]) < $signed(lo_c)) lo_c = poly_ff[0][v][a];
            if ($signed(poly_ff[0][v][a]) > $signed(hi_c)) hi_c = poly_ff[0][v][a];
         end
         span      = $signed({hi_c[COORD_W-1], hi_c}) - $signed({lo_c[COORD_W-1], lo_c});
         ext_in[a] = span[COORD_W-1:0];
         if (bmin_ff[a] == bmax_ff[a]) bflat = axis_type'(a);
         if (poly_ff[0][0][a] == poly_ff[0][1][a] && poly_ff[0][1][a] == poly_ff[0][2][a])
            tflat = axis_type'(a);
      end
   end

   // stable descending sort of the axes by extent; identity order for a flat triangle
   always_comb begin
      order_in[0] = 2'd0;
      order_in[1] = 2'd1;
      order_in[2] = 2'd2;
      tmp         = 2'd0;
      if (tflat_ff == AXIS_NONE) begin
         if (ext_ff[order_in[0]] < ext_ff[order_in[1]]) begin
            tmp = order_in[0]; order_in[0] = order_in[1]; order_in[1] = tmp;
         end
         if (ext_ff[order_in[1]] < ext_ff[order_in[2]]) begin
            tmp = order_in[1]; order_in[1] = order_in[2]; order_in[2] = tmp;
         end
         if (ext_ff[order_in[0]] < ext_ff[order_in[1]]) begin
            tmp = order_in[0]; order_in[0] = order_in[1]; order_in[1] = tmp;
         end
      end
   end

   always_comb begin
      case (pass_idx[2:1])
         2'd0:    axis = order_ff[0];
         2'd1:    axis = order_ff[1];
         default: axis = order_ff[2];
      endcase
      a0    = OTHER_AXES[axis][0];
      a1    = OTHER_AXES[axis][1];
      side  = pass_idx[0];
      plane = side ? bmax_ff[axis] : bmin_ff[axis];
      rd_v  = poly_ff[src][rd_idx];
      nxt_v = cmd.use_first ? first_ff : rd_v;
      cv    = c_ff[axis];
      nv    = nxt_v[axis];
      cin   = side ? ($signed(cv) <= $signed(plane)) : ($signed(cv) >= $signed(plane));
      nin   = side ? ($signed(nv) <= $signed(plane)) : ($signed(nv) >= $signed(plane));
      num_s = $signed({plane[COORD_W-1], plane}) - $signed({cv[COORD_W-1], cv});
      den_s = $signed({nv[COORD_W-1], nv}) - $signed({cv[COORD_W-1], cv});
      num_mag = num_s[COORD_W] ? (COORD_W+1)'(0) - num_s : num_s;
      den_mag = den_s[COORD_W] ? (COORD_W+1)'(0) - den_s : den_s;
      diff0 = $signed({nxt_v[a0][COORD_W-1], nxt_v[a0]})
            - $signed({c_ff[a0][COORD_W-1], c_ff[a0]});
      diff1 = $signed({nxt_v[a1][COORD_W-1], nxt_v[a1]})
            - $signed({c_ff[a1][COORD_W-1], c_ff[a1]});
      biased0 = prod_ff[0] + (prod_ff[0][PW-1] ? $signed(TRUNC_BIAS) : $signed(PW'(0)));
      biased1 = prod_ff[1] + (prod_ff[1][PW-1] ? $signed(TRUNC_BIAS) : $signed(PW'(0)));
      sh0 = biased0 >>> FRAC_BITS;
      sh1 = biased1 >>> FRAC_BITS;
      cross_v       = c_ff;
      cross_v[axis] = plane;
      cross_v[a0]   = c_ff[a0] + sh0[COORD_W-1:0];
      cross_v[a1]   = c_ff[a1] + sh1[COORD_W-1:0];
      for (int a = 0; a < NUM_AXES; a++) begin
         box_lo[a] = ($signed(lo_ff[a]) < $signed(bmin_ff[a])) ? bmin_ff[a] : lo_ff[a];
         box_hi[a] = ($signed(hi_ff[a]) > $signed(bmax_ff[a])) ? bmax_ff[a] : hi_ff[a];
      end
   end

   tbc_div #(.FRAC_BITS(FRAC_BITS)) u_div (
      .clock (clock),
      .reset (reset),
      .start (cmd.div_start),
      .num   (num_mag),
      .den   (den_mag),
      .quot  (quot),
      .done  (div_done)
   );

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         for (int v = 0; v < NUM_VERTS; v++)
            poly_ff[0][v] <= tri_in[v];
      end else if (cmd.write_cross) begin
         poly_ff[~src][wr_idx] <= cross_v;
      end else if (cmd.write_next) begin
         poly_ff[~src][wr_idx] <= nxt_v;
      end
      if (cmd.setup) begin
         bflat_ff <= bflat;
         tflat_ff <= tflat;
         ext_ff   <= ext_in;
      end
      if (cmd.order) order_ff <= order_in;
      if (cmd.load_first) begin
         c_ff     <= rd_v;
         first_ff <= rd_v;
      end else if (cmd.advance) begin
         c_ff <= nxt_v;
      end
      if (cmd.mul) begin
         prod_ff[0] <= $signed({1'b0, quot}) * diff0;
         prod_ff[1] <= $signed({1'b0, quot}) * diff1;
      end
      if (cmd.bbox_acc) begin
         for (int a = 0; a < NUM_AXES; a++) begin
            if (cmd.bbox_init || $signed(rd_v[a]) < $signed(lo_ff[a])) lo_ff[a] <= rd_v[a];
            if (cmd.bbox_init || $signed(rd_v[a]) > $signed(hi_ff[a])) hi_ff[a] <= rd_v[a];
         end
      end
      if (cmd.load_out) begin
         out_last_ff <= cmd.out_last;
         case (cmd.out_kind)
            OUT_VERT: begin
               out_lo_ff   <= rd_v;
               out_hi_ff   <= '0;
               out_user_ff <= 1'b1;
            end
            OUT_BOX: begin
               out_lo_ff   <= box_lo;
               out_hi_ff   <= box_hi;
               out_user_ff <= 1'b1;
            end
            default: begin
               out_lo_ff   <= '0;
               out_hi_ff   <= '0;
               out_user_ff <= 1'b0;
            end
         endcase
      end
   end

   always_comb begin
      status.reject = bflat_ff != AXIS_NONE && tflat_ff != AXIS_NONE &&
                      (tflat_ff != bflat_ff || poly_ff[0][0][tflat_ff] != bmin_ff[bflat_ff]);
      status.skip_pass  = axis == bflat_ff;
      status.emit_next  = (cin && nin) || (!cin && nin && nv != plane);
      status.emit_cross = (cin && !nin && cv != plane) || (!cin && nin);
      status.div_done   = div_done;
      status.mode       = mode_ff;
      status.out_last   = out_last_ff;
   end

   assign rsp_tdata = {out_hi_ff, out_lo_ff};
   assign rsp_tuser = out_user_ff;
   assign rsp_tlast = out_last_ff;
endmodule
`default_nettype wire

/* rtl/tbc_ctrl.sv */
// Controller: sequences setup, six clip passes, bounding box and result transactions.
`default_nettype none
module tbc_ctrl
   import tbc_pkg::*;
#(
   parameter int MAX_VERTS = 9
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_tvalid,
   output logic                              req_tready,
   output logic                              rsp_tvalid,
   input  wire logic                         rsp_tready,
   input  wire status_type                   status,
   output cmd_type                           cmd,
   output logic [PASS_W-1:0]                 pass_idx,
   output logic                              src,
   output logic [$clog2(MAX_VERTS)-1:0]      rd_idx,
   output logic [$clog2(MAX_VERTS)-1:0]      wr_idx
);
   localparam int IW = $clog2(MAX_VERTS);
   localparam int CW = $clog2(MAX_VERTS + 1);
   localparam logic [CW-1:0] MAX_CNT = CW'(MAX_VERTS);
   localparam logic [CW-1:0] TRI_CNT = CW'(NUM_VERTS);

   state_type         state_ff, state_in;
   logic [PASS_W-1:0] k_ff, k_in;
   logic [CW-1:0]     j_ff, j_in, cnt_ff, cnt_in, nout_ff, nout_in, oi_ff, oi_in;
   logic              src_ff, src_in, do_adv, room;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
      k_ff    <= k_in;
      j_ff    <= j_in;
      cnt_ff  <= cnt_in;
      nout_ff <= nout_in;
      oi_ff   <= oi_in;
      src_ff  <= src_in;
   end

   always_comb begin
      state_in      = state_ff;
      k_in          = k_ff;
      j_in          = j_ff;
      cnt_in        = cnt_ff;
      nout_in       = nout_ff;
      oi_in         = oi_ff;
      src_in        = src_ff;
      cmd           = '0;
      cmd.use_first = j_ff == cnt_ff;
      cmd.out_kind  = OUT_MISS;
      rd_idx        = j_ff[IW-1:0];
      req_tready    = 1'b0;
      rsp_tvalid    = 1'b0;
      do_adv        = 1'b0;
      room          = nout_ff < MAX_CNT;
      unique case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = S_SETUP;
            end
         end
         S_SETUP: begin
            cmd.setup = 1'b1;
            state_in  = S_ORDER;
         end
         S_ORDER: begin
            cmd.order = 1'b1;
            k_in      = '0;
            cnt_in    = TRI_CNT;
            src_in    = 1'b0;
            state_in  = status.reject ? S_MISS : S_PASS;
         end
         S_PASS: begin
            rd_idx = '0;
            if (k_ff == NUM_PASSES) begin
               state_in = S_FINISH;
            end else if (status.skip_pass || cnt_ff == '0) begin
               k_in = k_ff + 1'b1;
            end else begin
               cmd.load_first = 1'b1;
               j_in           = CW'(1);
               nout_in        = '0;
               state_in       = S_EDGE;
            end
         end
         S_EDGE: begin
            if (status.emit_cross && room) begin
               cmd.div_start = 1'b1;
               state_in      = S_DIV;
            end else if (status.emit_next && room) begin
               cmd.write_next = 1'b1;
               nout_in        = nout_ff + 1'b1;
               do_adv         = 1'b1;
            end else begin
               do_adv = 1'b1;
            end
         end
         S_DIV: begin
            if (status.div_done) state_in = S_MUL;
         end
         S_MUL: begin
            cmd.mul  = 1'b1;
            state_in = S_CROSS;
         end
         S_CROSS: begin
            cmd.write_cross = 1'b1;
            nout_in         = nout_ff + 1'b1;
            if (status.emit_next) state_in = S_NEXT;
            else do_adv = 1'b1;
         end
         S_NEXT: begin
            if (room) begin
               cmd.write_next = 1'b1;
               nout_in        = nout_ff + 1'b1;
            end
            do_adv = 1'b1;
         end
         S_FINISH: begin
            oi_in = '0;
            if (cnt_ff == '0) state_in = S_MISS;
            else if (status.mode) state_in = S_BBOX;
            else state_in = S_PREP;
         end
         S_BBOX: begin
            rd_idx        = oi_ff[IW-1:0];
            cmd.bbox_acc  = 1'b1;
            cmd.bbox_init = oi_ff == '0;
            if (oi_ff == cnt_ff - 1'b1) state_in = S_PREP;
            else oi_in = oi_ff + 1'b1;
         end
         S_PREP: begin
            rd_idx       = oi_ff[IW-1:0];
            cmd.load_out = 1'b1;
            if (status.mode) begin
               cmd.out_kind = OUT_BOX;
               cmd.out_last = 1'b1;
            end else begin
               cmd.out_kind = OUT_VERT;
               cmd.out_last = oi_ff == cnt_ff - 1'b1;
            end
            state_in = S_EMIT;
         end
         S_MISS: begin
            cmd.load_out = 1'b1;
            cmd.out_kind = OUT_MISS;
            cmd.out_last = 1'b1;
            state_in     = S_EMIT;
         end
         S_EMIT: begin
            rsp_tvalid = 1'b1;
            if (rsp_tready) begin
               if (status.out_last) begin
                  state_in = S_IDLE;
               end else begin
                  oi_in    = oi_ff + 1'b1;
                  state_in = S_PREP;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
      if (do_adv) begin
         cmd.advance = 1'b1;
         if (j_ff == cnt_ff) begin
            cnt_in   = nout_in;
            src_in   = ~src_ff;
            k_in     = k_ff + 1'b1;
            state_in = S_PASS;
         end else begin
            j_in     = j_ff + 1'b1;
            state_in = S_EDGE;
         end
      end
   end

   assign pass_idx = k_ff;
   assign src      = src_ff;
   assign wr_idx   = nout_ff[IW-1:0];
endmodule
`default_nettype wire

/* rtl/triangle_box_clipper_top.sv */
// Top level of the triangle box clipper: controller, datapath and configuration port.
//
// One request transaction carries a triangle (nine Q16.16 coordinates). The
// triangle is clipped against the box in the csr_ registers, axes in order of
// descending extent, lower then upper plane. In polygon mode every vertex of
// the clipped polygon is one response transaction, the final one with tlast;
// in box mode one transaction carries the clamped bounding box. A miss gives
// one transaction with tuser clear, tlast set and zero data.
// Items are taken one at a time: req_tready is high only while idle.
// From the accepting edge the controller runs the setup and order states, then
// each clip pass starts in the pass state and walks the polygon edges; an edge
// that crosses the plane goes through the bit-serial divider, the multiply and
// the write, and the next vertex is written after the crossing when it follows
// it. A skipped pass only steps the pass index, and the finish state closes the
// passes. Each response transaction is loaded and then presented; box mode
// first walks the polygon vertices for the bounding box.
// Reset is synchronous: the controller returns to idle and the box registers
// and mode clear to zero. A stalled response holds the controller in place
// with the response steady; no request is taken until the last one is taken.
`default_nettype none
module triangle_box_clipper_top
   import tbc_pkg::*;
#(
   parameter int MAX_VERTS = 9,
   parameter int FRAC_BITS = 16
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_we,
   input  wire logic [CSR_ADDR_W-1:0] csr_addr,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   // v0_x, v0_y, v0_z, v1_x, v1_y, v1_z, v2_x, v2_y, v2_z
   input  wire logic [REQ_W-1:0]      req_tdata,
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   // coord_x, coord_y, coord_z, upper_x, upper_y, upper_z
   output logic [RSP_W-1:0]           rsp_tdata,
   // intersects
   output logic                       rsp_tuser,
   output logic                       rsp_tlast
);
   localparam int IW = $clog2(MAX_VERTS);

   cmd_type           cmd;
   status_type        status;
   logic [PASS_W-1:0] pass_idx;
   logic              src;
   logic [IW-1:0]     rd_idx, wr_idx;

   tbc_ctrl #(.MAX_VERTS(MAX_VERTS)) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd),
      .pass_idx   (pass_idx),
      .src        (src),
      .rd_idx     (rd_idx),
      .wr_idx     (wr_idx)
   );

   tbc_datapath #(.MAX_VERTS(MAX_VERTS), .FRAC_BITS(FRAC_BITS)) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .req_tdata (req_tdata),
      .cmd       (cmd),
      .pass_idx  (pass_idx),
      .src       (src),
      .rd_idx    (rd_idx),
      .wr_idx    (wr_idx),
      .status    (status),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser),
      .rsp_tlast (rsp_tlast)
   );
endmodule
`default_nettype wire

/* rtl/tbc_checker.sv */
// Port checker for the triangle box clipper and its bind to the top level.
`default_nettype none
module tbc_checker
   import tbc_pkg::*;
(
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             req_tvalid,
   input wire logic             req_tready,
   input wire logic             rsp_tvalid,
   input wire logic             rsp_tready,
   input wire logic [RSP_W-1:0] rsp_tdata,
   input wire logic             rsp_tuser,
   input wire logic             rsp_tlast
);
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("response changed while stalled");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid))
      else $error("request taken while a response is pending");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_tvalid && req_tready)
      else $error("not idle after reset");

   a_miss_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tlast && rsp_tdata == '0)
      else $error("miss transaction not final or not zero");

   a_accept_gap: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request accepted on consecutive cycles");
endmodule

bind triangle_box_clipper_top tbc_checker u_tbc_checker (.*);
`default_nettype wire

/* tb/triangle_box_clipper_top_tb.sv */
// Self-checking testbench of the triangle box clipper: directed table, random phases, scoreboard.
`timescale 1ns / 1ps
module triangle_box_clipper_top_tb;
   import tbc_pkg::*;

   localparam int ONE = 65536;

   typedef struct packed {
      logic             isect;
      logic             last;
      logic [RSP_W-1:0] data;
   } rsp_type;

   typedef struct {
      bit               is_cfg;
      csr_idx_type      idx;
      logic [31:0]      val;
      logic [REQ_W-1:0] corners;
      bit               miss;
   } row_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  csr_we = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_addr = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_W-1:0]      req_tdata = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_W-1:0]      rsp_tdata;
   logic                  rsp_tuser;
   logic                  rsp_tlast;

   logic signed [31:0] box_lo [3];
   logic signed [31:0] box_hi [3];
   logic               box_mode;
   rsp_type            clipped_q [$];
   row_type            plan [$];
   int                 mismatches = 0;
   int                 burst_left = 0;
   bit                 hold_rsp = 0;

   triangle_box_clipper_top u_top (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always #2 clock = ~clock;

   initial begin
      #20ms;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   function automatic longint cross_at(longint ca, longint na, longint plane, longint co,
                                       longint no);
      longint t;
      if (na == ca) return co;
      t = ((plane - ca) * ONE) / (na - ca);
      return co + (t * (no - co)) / ONE;
   endfunction

   task automatic queue_rsp(input rsp_type r);
      clipped_q = {clipped_q, r};
   endtask

   task automatic add_row(input row_type r);
      plan = {plan, r};
   endtask

   task automatic push_miss();
      rsp_type r;
      r = '0;
      r.last = 1'b1;
      queue_rsp(r);
   endtask

   task automatic clip_triangle(input logic [REQ_W-1:0] d);
      longint tv [3][3];
      longint poly [2][9][3];
      longint ext [3];
      longint lo [3];
      longint hi [3];
      longint plane, cv, nv;
      int order [3];
      int box_flat, tri_flat, cnt, src, n, axis, side, nxt, tmp, j;
      bit cin, nin, ec, en;
      rsp_type r;
      box_flat = 3;
      tri_flat = 3;
      cnt = 3;
      src = 0;
      order = '{0, 1, 2};
      for (int v = 0; v < 3; v++)
         for (int a = 0; a < 3; a++)
            tv[v][a] = $signed(d[(v*3+a)*32 +: 32]);
      for (int a = 0; a < 3; a++) begin
         if (box_lo[a] == box_hi[a]) box_flat = a;
         if (tv[0][a] == tv[1][a] && tv[1][a] == tv[2][a]) tri_flat = a;
      end
      if (box_flat < 3 && tri_flat < 3 &&
          (tri_flat != box_flat || tv[0][tri_flat] != box_lo[box_flat])) begin
         push_miss();
         return;
      end
      if (tri_flat == 3) begin
         for (int a = 0; a < 3; a++) begin
            lo[a] = tv[0][a];
            hi[a] = tv[0][a];
            for (int v = 1; v < 3; v++) begin
               if (tv[v][a] < lo[a]) lo[a] = tv[v][a];
               if (tv[v][a] > hi[a]) hi[a] = tv[v][a];
            end
            ext[a] = hi[a] - lo[a];
         end
         for (int i = 1; i < 3; i++) begin
            j = i;
            while (j > 0 && ext[order[j-1]] < ext[order[j]]) begin
               tmp = order[j];
               order[j] = order[j-1];
               order[j-1] = tmp;
               j--;
            end
         end
      end
      for (int v = 0; v < 3; v++)
         for (int a = 0; a < 3; a++)
            poly[0][v][a] = tv[v][a];
      for (int k = 0; k < 6; k++) begin
         axis = order[k >> 1];
         side = k & 1;
         plane = side ? box_hi[axis] : box_lo[axis];
         if (axis == box_flat) continue;
         n = 0;
         for (int cur = 0; cur < cnt; cur++) begin
            nxt = (cur + 1) % cnt;
            cv = poly[src][cur][axis];
            nv = poly[src][nxt][axis];
            cin = side ? (cv <= plane) : (cv >= plane);
            nin = side ? (nv <= plane) : (nv >= plane);
            ec = 0;
            en = 0;
            if (cin && nin) en = 1;
            else if (cin) ec = (cv != plane);
            else if (nin) begin
               ec = 1;
               en = (nv != plane);
            end
            if (ec && n < 9) begin
               for (int a = 0; a < 3; a++)
                  poly[src^1][n][a] = (a == axis) ? plane :
                     cross_at(cv, nv, plane, poly[src][cur][a], poly[src][nxt][a]);
               n++;
            end
            if (en && n < 9) begin
               for (int a = 0; a < 3; a++) poly[src^1][n][a] = poly[src][nxt][a];
               n++;
            end
         end
         cnt = n;
         src ^= 1;
      end
      if (cnt == 0) begin
         push_miss();
         return;
      end
      if (box_mode == 1'b0) begin
         for (int i = 0; i < cnt; i++) begin
            r = '0;
            r.isect = 1'b1;
            r.last = (i == cnt - 1);
            for (int a = 0; a < 3; a++) r.data[a*32 +: 32] = poly[src][i][a][31:0];
            queue_rsp(r);
         end
         return;
      end
      r = '0;
      r.isect = 1'b1;
      r.last = 1'b1;
      for (int a = 0; a < 3; a++) begin
         lo[a] = poly[src][0][a];
         hi[a] = poly[src][0][a];
         for (int i = 1; i < cnt; i++) begin
            if (poly[src][i][a] < lo[a]) lo[a] = poly[src][i][a];
            if (poly[src][i][a] > hi[a]) hi[a] = poly[src][i][a];
         end
         if (lo[a] < box_lo[a]) lo[a] = box_lo[a];
         if (hi[a] > box_hi[a]) hi[a] = box_hi[a];
         r.data[a*32 +: 32] = lo[a][31:0];
         r.data[(a+3)*32 +: 32] = hi[a][31:0];
      end
      queue_rsp(r);
   endtask

   // response side: scoreboard and stall pattern
   initial begin
      rsp_type want;
      int style;
      int style_left;
      style = 0;
      style_left = 0;
      forever begin
         @(posedge clock);
         if (rsp_tvalid && rsp_tready) begin
            if (clipped_q.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected response: user %0b last %0b data %h",
                           rsp_tuser, rsp_tlast, rsp_tdata);
            end else begin
               want = clipped_q.pop_front();
               if (rsp_tuser !== want.isect || rsp_tlast !== want.last ||
                   rsp_tdata !== want.data) begin
                  mismatches++;
                  if (mismatches <= 10) begin
                     $display("mismatch: intersects exp %0b got %0b, last exp %0b got %0b",
                              want.isect, rsp_tuser, want.last, rsp_tlast);
                     for (int f = 0; f < 6; f++)
                        $display("  field %0d exp %h got %h", f, want.data[f*32 +: 32],
                                 rsp_tdata[f*32 +: 32]);
                  end
               end
            end
         end
         if (hold_rsp) begin
            rsp_tready <= 1'b0;
            repeat (600) @(posedge clock);
            hold_rsp = 0;
         end else begin
            if (style_left == 0) begin
               style = $urandom_range(0, 2);
               style_left = $urandom_range(10, 80);
            end
            style_left--;
            case (style)
               0: rsp_tready <= 1'b1;
               1: rsp_tready <= 1'($urandom_range(0, 1));
               default: rsp_tready <= ($urandom_range(0, 3) == 0);
            endcase
         end
      end
   end

   task automatic set_reg(input csr_idx_type idx, input logic [31:0] v);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_addr <= idx;
      csr_wdata <= v;
      case (idx)
         CSR_BOX_MIN_X: box_lo[0] = v;
         CSR_BOX_MIN_Y: box_lo[1] = v;
         CSR_BOX_MIN_Z: box_lo[2] = v;
         CSR_BOX_MAX_X: box_hi[0] = v;
         CSR_BOX_MAX_Y: box_hi[1] = v;
         CSR_BOX_MAX_Z: box_hi[2] = v;
         CSR_OUTPUT_MODE: box_mode = v[0];
         default: ;
      endcase
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic drain();
      @(posedge clock);
      req_tvalid <= 1'b0;
      while (clipped_q.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic offer(input logic [REQ_W-1:0] d, input bit known_miss);
      req_tdata <= d;
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      if (known_miss) push_miss();
      else clip_triangle(d);
      if (burst_left == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
         burst_left = $urandom_range(0, 10);
      end else begin
         burst_left--;
      end
   endtask

   function automatic logic [REQ_W-1:0] corners9(input logic [31:0] a, b, c, d, e, f, g, h,
                                                 k);
      return {k, h, g, f, e, d, c, b, a};
   endfunction

   function automatic logic [31:0] near_coord(input int ax);
      longint lo_v, hi_v, mid, sp, c;
      case ($urandom_range(0, 9))
         0: return $urandom;
         1: return box_lo[ax];
         2: return box_hi[ax];
         default: ;
      endcase
      lo_v = box_lo[ax];
      hi_v = box_hi[ax];
      mid = (lo_v + hi_v) / 2;
      sp = ((hi_v > lo_v) ? hi_v - lo_v : lo_v - hi_v) + 4 * ONE;
      if (sp > 64'h3fffffff) return $urandom;
      c = mid + longint'($urandom_range(0, 32'(2 * sp))) - sp;
      if (c > 64'sh7fffffff) c = 64'sh7fffffff;
      if (c < -64'sh80000000) c = -64'sh80000000;
      return c[31:0];
   endfunction

   function automatic logic [REQ_W-1:0] random_corners();
      logic [REQ_W-1:0] d;
      int ax;
      logic [31:0] flat_v;
      if ($urandom_range(0, 9) == 0) begin
         for (int w = 0; w < 9; w++) d[w*32 +: 32] = $urandom;
         return d;
      end
      for (int w = 0; w < 9; w++) d[w*32 +: 32] = near_coord(w % 3);
      if ($urandom_range(0, 5) == 0) begin
         ax = $urandom_range(0, 2);
         flat_v = $urandom_range(0, 1) ? box_lo[ax] : d[ax*32 +: 32];
         for (int v = 0; v < 3; v++) d[(v*3+ax)*32 +: 32] = flat_v;
      end
      return d;
   endfunction

   function automatic row_type cfg_row(input csr_idx_type idx, input logic [31:0] v);
      row_type r;
      r.is_cfg = 1;
      r.idx = idx;
      r.val = v;
      r.corners = '0;
      r.miss = 0;
      return r;
   endfunction

   function automatic row_type tri_row(input logic [REQ_W-1:0] d, input bit miss);
      row_type r;
      r.is_cfg = 0;
      r.idx = CSR_BOX_MIN_X;
      r.val = '0;
      r.corners = d;
      r.miss = miss;
      return r;
   endfunction

   task automatic set_box(input logic [31:0] lx, ly, lz, hx, hy, hz, input bit m);
      set_reg(CSR_BOX_MIN_X, lx);
      set_reg(CSR_BOX_MIN_Y, ly);
      set_reg(CSR_BOX_MIN_Z, lz);
      set_reg(CSR_BOX_MAX_X, hx);
      set_reg(CSR_BOX_MAX_Y, hy);
      set_reg(CSR_BOX_MAX_Z, hz);
      set_reg(CSR_OUTPUT_MODE, {31'd0, m});
   endtask

   initial begin
      logic [31:0] lo_v [3];
      logic [31:0] hi_v [3];
      bit prev_cfg;
      for (int a = 0; a < 3; a++) begin
         box_lo[a] = 0;
         box_hi[a] = 0;
      end
      box_mode = 0;

      add_row(tri_row(corners9(0, 0, 5*ONE, ONE, 0, 5*ONE, 0, ONE, 5*ONE), 1));
      add_row(tri_row(corners9(-ONE, -ONE, ONE, 2*ONE, -ONE, 3*ONE, 0, 3*ONE,
                               5*ONE), 0));
      add_row(cfg_row(CSR_BOX_MIN_X, -10*ONE));
      add_row(cfg_row(CSR_BOX_MIN_Y, -10*ONE));
      add_row(cfg_row(CSR_BOX_MIN_Z, -10*ONE));
      add_row(cfg_row(CSR_BOX_MAX_X, 10*ONE));
      add_row(cfg_row(CSR_BOX_MAX_Y, 10*ONE));
      add_row(cfg_row(CSR_BOX_MAX_Z, 10*ONE));
      add_row(cfg_row(CSR_OUTPUT_MODE, 0));
      add_row(tri_row(corners9(ONE, ONE, ONE, 2*ONE, 3*ONE, 4*ONE, -5*ONE, 0,
                               2*ONE), 0));
      add_row(tri_row(corners9(-20*ONE, 0, 0, 20*ONE, ONE, 2*ONE, 0, 30*ONE,
                               -3*ONE), 0));
      add_row(tri_row(corners9(20*ONE, 0, 0, 30*ONE, ONE, ONE, 25*ONE, 5*ONE,
                               2*ONE), 1));
      add_row(tri_row(corners9(10*ONE, 0, 0, 15*ONE, 5*ONE, 0, 10*ONE, 5*ONE,
                               5*ONE), 0));
      add_row(tri_row(corners9(-40*ONE, -40*ONE, -40*ONE, 60*ONE, -30*ONE, 40*ONE,
                               -20*ONE, 70*ONE, 10*ONE), 0));
      add_row(tri_row(corners9(32'h80000000, 32'h80000000, 32'h7fffffff,
                               32'h7fffffff, 32'h80000000, 32'h80000000,
                               32'h80000000, 32'h7fffffff, 32'h00012345), 0));
      add_row(cfg_row(CSR_OUTPUT_MODE, 1));
      add_row(tri_row(corners9(-20*ONE, 0, 0, 20*ONE, ONE, 2*ONE, 0, 30*ONE,
                               -3*ONE), 0));
      add_row(tri_row(corners9(-40*ONE, -40*ONE, -40*ONE, 60*ONE, -30*ONE, 40*ONE,
                               -20*ONE, 70*ONE, 10*ONE), 0));
      add_row(tri_row(corners9(20*ONE, 0, 0, 30*ONE, ONE, ONE, 25*ONE, 5*ONE,
                               2*ONE), 1));
      add_row(cfg_row(CSR_BOX_MIN_Z, 3*ONE));
      add_row(cfg_row(CSR_BOX_MAX_Z, 3*ONE));
      add_row(cfg_row(CSR_OUTPUT_MODE, 0));
      add_row(tri_row(corners9(-20*ONE, 0, 3*ONE, 20*ONE, ONE, 3*ONE, 0, 30*ONE,
                               3*ONE), 0));
      add_row(tri_row(corners9(0, 0, 4*ONE, ONE, 0, 4*ONE, 0, ONE, 4*ONE), 1));
      add_row(tri_row(corners9(ONE, 0, 0, ONE, 2*ONE, ONE, ONE, 0, 5*ONE), 1));
      add_row(cfg_row(CSR_BOX_MIN_X, 20*ONE));
      add_row(cfg_row(CSR_BOX_MAX_X, -20*ONE));
      add_row(cfg_row(CSR_BOX_MIN_Z, -10*ONE));
      add_row(cfg_row(CSR_BOX_MAX_Z, 10*ONE));
      add_row(tri_row(corners9(-30*ONE, 0, 0, 30*ONE, ONE, 2*ONE, 0, 5*ONE,
                               -3*ONE), 0));
      add_row(cfg_row(CSR_BOX_MIN_X, 32'h80000000));
      add_row(cfg_row(CSR_BOX_MIN_Y, 32'h80000000));
      add_row(cfg_row(CSR_BOX_MIN_Z, 32'h80000000));
      add_row(cfg_row(CSR_BOX_MAX_X, 32'h7fffffff));
      add_row(cfg_row(CSR_BOX_MAX_Y, 32'h7fffffff));
      add_row(cfg_row(CSR_BOX_MAX_Z, 32'h7fffffff));
      add_row(cfg_row(CSR_OUTPUT_MODE, 1));
      add_row(tri_row(corners9(32'h80000000, 32'h80000000, 32'h7fffffff,
                               32'h7fffffff, 32'h80000000, 32'h80000000,
                               32'h80000000, 32'h7fffffff, 32'h00012345), 0));
      add_row(tri_row(corners9(32'hdeadbeef, 32'h01234567, 32'h89abcdef,
                               32'h76543210, 32'hfedcba98, 32'h55aa55aa,
                               32'haa55aa55, 32'h0f0f0f0f, 32'hf0f0f0f0), 0));

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      prev_cfg = 0;
      foreach (plan[i]) begin
         if (plan[i].is_cfg) begin
            if (!prev_cfg) drain();
            set_reg(plan[i].idx, plan[i].val);
         end else begin
            offer(plan[i].corners, plan[i].miss);
         end
         prev_cfg = plan[i].is_cfg;
      end

      for (int phase = 0; phase < 8; phase++) begin
         drain();
         for (int a = 0; a < 3; a++) begin
            case ((phase == 7) ? 3 : $urandom_range(0, 5))
               0: begin
                  lo_v[a] = 32'h80000000;
                  hi_v[a] = 32'h7fffffff;
               end
               1: begin
                  hi_v[a] = ($urandom_range(0, 200) - 100) * ONE;
                  lo_v[a] = hi_v[a] + $urandom_range(1, 50) * ONE;
               end
               2: begin
                  lo_v[a] = $urandom;
                  hi_v[a] = $urandom;
               end
               3: begin
                  lo_v[a] = ($urandom_range(0, 200) - 100) * ONE;
                  hi_v[a] = lo_v[a];
               end
               default: begin
                  lo_v[a] = ($urandom_range(0, 150) - 100) * ONE + $urandom_range(0, ONE - 1);
                  hi_v[a] = lo_v[a] + $urandom_range(0, 100 * ONE);
               end
            endcase
         end
         set_box(lo_v[0], lo_v[1], lo_v[2], hi_v[0], hi_v[1], hi_v[2],
                 1'($urandom_range(0, 1)));
         for (int n = 0; n < 40; n++) begin
            if (phase == 2 && n == 10) hold_rsp = 1;
            if (phase == 4 && n == 20) drain();
            offer(random_corners(), 0);
         end
      end

      drain();
      repeat (300) @(posedge clock);
      if (mismatches == 0 && clipped_q.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end
endmodule
